[rtl/core/gpk_pkg.sv]
`timescale 1ns / 1ps
package gpk_pkg;

    // field and port widths
    localparam int BLK_W      = 7;
    localparam int PIX_W      = 20;
    localparam int BPIX_W     = 13;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 112;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_GRID_WIDE  = 2'd0;
    localparam logic [1:0] REG_GRID_HIGH  = 2'd1;
    localparam logic [1:0] REG_BLOCK_PX_W = 2'd2;
    localparam logic [1:0] REG_BLOCK_PX_H = 2'd3;

    // register reset values
    localparam logic [BLK_W-1:0]  GRID_RESET = 7'd64;
    localparam logic [BPIX_W-1:0] BPIX_RESET = 13'd16;

    // opcode of an input transaction
    localparam logic OP_CLEAR = 1'b1;

    // stored block bounds of one rectangle
    typedef struct packed {
        logic [BLK_W-1:0] l;
        logic [BLK_W-1:0] t;
        logic [BLK_W-1:0] r;
        logic [BLK_W-1:0] b;
    } gpk_bnd_t;

    // which cell walk the datapath is on
    typedef enum logic [1:0] {
        PH_TOP,
        PH_LEFT,
        PH_RIGHT,
        PH_SKIP
    } gpk_phase_t;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_SWEEP_INIT,
        CMD_SWEEP,
        CMD_CLR_DONE,
        CMD_DIVW_INIT,
        CMD_DIV_STEP,
        CMD_DIVW_SAVE,
        CMD_DIVH_SAVE,
        CMD_SETUP,
        CMD_READ,
        CMD_CELL,
        CMD_ADV,
        CMD_HIT,
        CMD_PROBE,
        CMD_ROW_END,
        CMD_PLACE,
        CMD_MARK,
        CMD_RESULT,
        CMD_FAIL
    } gpk_cmd_t;

    // controller states
    typedef enum logic [4:0] {
        S_WIPE_INIT,
        S_WIPE,
        S_IDLE,
        S_PRECHK,
        S_CLR,
        S_CLR_OUT,
        S_DIVW,
        S_DIVW_SAVE,
        S_DIVH,
        S_DIVH_SAVE,
        S_CHECK,
        S_RD,
        S_CELL,
        S_BND,
        S_NEXT,
        S_SKIPCHK,
        S_YCHK,
        S_PLACE,
        S_MARK,
        S_RESULT,
        S_FAIL
    } gpk_state_t;

    // datapath status towards the controller
    typedef struct packed {
        logic       cfg_dim_wr;
        logic       sweep_last;
        logic       op_clear;
        logic       bad_req;
        logic       div_last;
        logic       too_big;
        logic       cell_hit;
        logic       bnd_err;
        logic       x_ge_r;
        logic       i_last;
        logic       hb_one;
        logic       skip_more;
        logic       x_lt_xmax;
        logic       y_ge_ymax;
        logic       mark_done;
        logic       out_busy;
        gpk_phase_t phase;
    } gpk_status_t;

endpackage

[rtl/core/gpk_ctrl.sv]
`timescale 1ns / 1ps
module gpk_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gpk_pkg::gpk_status_t st,
    output gpk_pkg::gpk_cmd_t   cmd
);

    gpk_pkg::gpk_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gpk_pkg::S_WIPE_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = gpk_pkg::CMD_NOP;
        s_tready   = 1'b0;
        case (state_reg)
            gpk_pkg::S_WIPE_INIT: begin
                cmd        = gpk_pkg::CMD_SWEEP_INIT;
                // a grid dimension write here needs a fresh free count
                state_next = st.cfg_dim_wr ? gpk_pkg::S_WIPE_INIT : gpk_pkg::S_WIPE;
            end
            gpk_pkg::S_WIPE: begin
                if (st.cfg_dim_wr) begin
                    state_next = gpk_pkg::S_WIPE_INIT;
                end else begin
                    cmd = gpk_pkg::CMD_SWEEP;
                    if (st.sweep_last) state_next = gpk_pkg::S_IDLE;
                end
            end
            gpk_pkg::S_IDLE: begin
                if (st.cfg_dim_wr) begin
                    state_next = gpk_pkg::S_WIPE_INIT;
                end else begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        cmd        = gpk_pkg::CMD_LOAD;
                        state_next = gpk_pkg::S_PRECHK;
                    end
                end
            end
            gpk_pkg::S_PRECHK: begin
                if (st.op_clear) begin
                    cmd        = gpk_pkg::CMD_SWEEP_INIT;
                    state_next = gpk_pkg::S_CLR;
                end else if (st.bad_req) begin
                    state_next = gpk_pkg::S_FAIL;
                end else begin
                    cmd        = gpk_pkg::CMD_DIVW_INIT;
                    state_next = gpk_pkg::S_DIVW;
                end
            end
            gpk_pkg::S_CLR: begin
                cmd = gpk_pkg::CMD_SWEEP;
                if (st.sweep_last) state_next = gpk_pkg::S_CLR_OUT;
            end
            gpk_pkg::S_CLR_OUT: begin
                if (!st.out_busy) begin
                    cmd        = gpk_pkg::CMD_CLR_DONE;
                    state_next = gpk_pkg::S_IDLE;
                end
            end
            gpk_pkg::S_DIVW: begin
                cmd = gpk_pkg::CMD_DIV_STEP;
                if (st.div_last) state_next = gpk_pkg::S_DIVW_SAVE;
            end
            gpk_pkg::S_DIVW_SAVE: begin
                cmd        = gpk_pkg::CMD_DIVW_SAVE;
                state_next = gpk_pkg::S_DIVH;
            end
            gpk_pkg::S_DIVH: begin
                cmd = gpk_pkg::CMD_DIV_STEP;
                if (st.div_last) state_next = gpk_pkg::S_DIVH_SAVE;
            end
            gpk_pkg::S_DIVH_SAVE: begin
                cmd        = gpk_pkg::CMD_DIVH_SAVE;
                state_next = gpk_pkg::S_CHECK;
            end
            gpk_pkg::S_CHECK: begin
                if (st.too_big) begin
                    state_next = gpk_pkg::S_FAIL;
                end else begin
                    cmd        = gpk_pkg::CMD_SETUP;
                    state_next = gpk_pkg::S_RD;
                end
            end
            gpk_pkg::S_RD: begin
                cmd        = gpk_pkg::CMD_READ;
                state_next = gpk_pkg::S_CELL;
            end
            gpk_pkg::S_CELL: begin
                if (st.cell_hit) begin
                    cmd        = gpk_pkg::CMD_CELL;
                    state_next = gpk_pkg::S_BND;
                end else begin
                    cmd = gpk_pkg::CMD_ADV;
                    case (st.phase)
                        gpk_pkg::PH_SKIP:  state_next = gpk_pkg::S_SKIPCHK;
                        gpk_pkg::PH_TOP:   state_next = (st.i_last && st.hb_one) ?
                                                        gpk_pkg::S_PLACE : gpk_pkg::S_RD;
                        gpk_pkg::PH_RIGHT: state_next = st.i_last ?
                                                        gpk_pkg::S_PLACE : gpk_pkg::S_RD;
                        default:           state_next = gpk_pkg::S_RD;
                    endcase
                end
            end
            gpk_pkg::S_BND: begin
                case (st.phase)
                    gpk_pkg::PH_TOP: begin
                        if (st.bnd_err || st.x_ge_r) begin
                            state_next = gpk_pkg::S_FAIL;
                        end else begin
                            cmd        = gpk_pkg::CMD_HIT;
                            state_next = gpk_pkg::S_NEXT;
                        end
                    end
                    gpk_pkg::PH_RIGHT: begin
                        if (st.x_ge_r) begin
                            state_next = gpk_pkg::S_FAIL;
                        end else begin
                            cmd        = gpk_pkg::CMD_HIT;
                            state_next = gpk_pkg::S_NEXT;
                        end
                    end
                    default: begin
                        cmd        = gpk_pkg::CMD_HIT;
                        state_next = gpk_pkg::S_SKIPCHK;
                    end
                endcase
            end
            gpk_pkg::S_SKIPCHK: begin
                state_next = st.skip_more ? gpk_pkg::S_RD : gpk_pkg::S_NEXT;
            end
            gpk_pkg::S_NEXT: begin
                if (st.x_lt_xmax) begin
                    cmd        = gpk_pkg::CMD_PROBE;
                    state_next = gpk_pkg::S_RD;
                end else begin
                    cmd        = gpk_pkg::CMD_ROW_END;
                    state_next = gpk_pkg::S_YCHK;
                end
            end
            gpk_pkg::S_YCHK: begin
                state_next = st.y_ge_ymax ? gpk_pkg::S_FAIL : gpk_pkg::S_RD;
            end
            gpk_pkg::S_PLACE: begin
                cmd        = gpk_pkg::CMD_PLACE;
                state_next = gpk_pkg::S_MARK;
            end
            gpk_pkg::S_MARK: begin
                cmd = gpk_pkg::CMD_MARK;
                if (st.mark_done) state_next = gpk_pkg::S_RESULT;
            end
            gpk_pkg::S_RESULT: begin
                if (!st.out_busy) begin
                    cmd        = gpk_pkg::CMD_RESULT;
                    state_next = gpk_pkg::S_IDLE;
                end
            end
            gpk_pkg::S_FAIL: begin
                if (!st.out_busy) begin
                    cmd        = gpk_pkg::CMD_FAIL;
                    state_next = gpk_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gpk_pkg::S_WIPE_INIT;
            end
        endcase
    end

endmodule

[rtl/core/gpk_datapath.sv]
`timescale 1ns / 1ps
module gpk_datapath #(
    parameter int MAX_BLOCKS_WIDE = 64,
    parameter int MAX_BLOCKS_HIGH = 64,
    parameter int MAX_RECTS       = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  gpk_pkg::gpk_cmd_t                cmd,
    output gpk_pkg::gpk_status_t             st,
    input  logic [gpk_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gpk_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gpk_pkg::APB_AW-1:0]       paddr,
    input  logic [gpk_pkg::APB_DW-1:0]       pwdata,
    output logic [gpk_pkg::APB_DW-1:0]       prdata
);

    localparam int CELLS  = MAX_BLOCKS_WIDE * MAX_BLOCKS_HIGH;
    localparam int CIDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RIDX_W = $clog2(MAX_RECTS);
    localparam int CW     = (MAX_BLOCKS_WIDE < 127) ? MAX_BLOCKS_WIDE : 127;
    localparam int CH     = (MAX_BLOCKS_HIGH < 127) ? MAX_BLOCKS_HIGH : 127;
    localparam int FREE_W = $clog2(CW * CH + 1);

    // configuration registers
    logic [6:0]  gw_reg, gh_reg;
    logic [12:0] bpw_reg, bph_reg;

    // item registers
    logic        op_reg;
    logic [7:0]  id_reg;
    logic [15:0] wpx_reg, hpx_reg;

    // divider
    logic [15:0] div_q_reg;
    logic [12:0] div_r_reg;
    logic [3:0]  div_cnt_reg;
    logic        div_sel_reg;

    // search state
    logic [16:0]          wb_reg, hb_reg;
    logic [7:0]           x_reg, y_reg, dest_reg, xmax_reg, ymax_reg;
    logic [6:0]           i_reg;
    gpk_pkg::gpk_phase_t  phase_reg;
    logic                 low_valid_reg;
    logic [6:0]           low_reg;
    logic [FREE_W-1:0]    free_reg;
    logic [CIDX_W-1:0]    sweep_idx_reg;
    logic [8:0]           cell_q_reg;
    logic                 cell_ok_reg;
    gpk_pkg::gpk_bnd_t    bnd_q_reg;
    logic                 bnd_ok_reg;
    logic [19:0]          pl_reg, pt_reg;

    // output register
    logic                            m_tvalid_reg;
    logic                            m_tuser_reg;
    logic [gpk_pkg::M_TDATA_W-1:0]   m_tdata_reg;

    // memories
    logic [8:0]          cell_mem [CELLS];
    gpk_pkg::gpk_bnd_t   bnd_mem  [MAX_RECTS];

    // combinational helpers
    logic                cfg_wr;
    logic [1:0]          reg_idx;
    logic [6:0]          cols, rows, wb7, hb7, x7;
    logic [12:0]         bw_eff, bh_eff, dvs;
    logic [13:0]         div_t, area;
    logic [7:0]          cx, cy;
    logic [15:0]         addr;
    logic                addr_ok;
    logic [CIDX_W-1:0]   cidx;
    gpk_pkg::gpk_bnd_t   hit;
    logic                i_last, hb_one;
    logic [19:0]         rpx, bpx;

    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // grid in use, saturated to the storage
    always_comb begin
        if (gw_reg == 7'd0) cols = 7'd1;
        else if ({25'b0, gw_reg} > 32'(MAX_BLOCKS_WIDE)) cols = 7'(MAX_BLOCKS_WIDE);
        else cols = gw_reg;
        if (gh_reg == 7'd0) rows = 7'd1;
        else if ({25'b0, gh_reg} > 32'(MAX_BLOCKS_HIGH)) rows = 7'(MAX_BLOCKS_HIGH);
        else rows = gh_reg;
    end

    assign bw_eff = (bpw_reg == 13'd0) ? 13'd1 : bpw_reg;
    assign bh_eff = (bph_reg == 13'd0) ? 13'd1 : bph_reg;
    assign dvs    = div_sel_reg ? bh_eff : bw_eff;
    assign div_t  = {div_r_reg, div_q_reg[15]};
    assign wb7    = wb_reg[6:0];
    assign hb7    = hb_reg[6:0];
    assign x7     = x_reg[6:0];
    assign area   = {7'b0, wb7} * {7'b0, hb7};

    // cell coordinate of the current walk
    always_comb begin
        case (phase_reg)
            gpk_pkg::PH_TOP: begin
                cx = x_reg + {1'b0, i_reg};
                cy = y_reg;
            end
            gpk_pkg::PH_LEFT: begin
                cx = x_reg;
                cy = y_reg + {1'b0, i_reg};
            end
            gpk_pkg::PH_RIGHT: begin
                cx = x_reg + {1'b0, wb7} - 8'd1;
                cy = y_reg + {1'b0, i_reg};
            end
            default: begin
                cx = x_reg;
                cy = y_reg;
            end
        endcase
    end

    assign addr    = ({8'b0, cy} * {9'b0, cols}) + {8'b0, cx};
    assign addr_ok = {16'b0, addr} < 32'(CELLS);
    assign cidx    = addr[CIDX_W-1:0];
    assign hit     = bnd_ok_reg ? bnd_q_reg : '0;
    assign hb_one  = (hb7 == 7'd1);
    assign i_last  = (phase_reg == gpk_pkg::PH_TOP) ? (i_reg == wb7 - 7'd1)
                                                     : (i_reg == hb7 - 7'd1);
    assign rpx     = pl_reg + {4'b0, wpx_reg};
    assign bpx     = pt_reg + {4'b0, hpx_reg};

    // status
    always_comb begin
        st.cfg_dim_wr = cfg_wr && ((reg_idx == gpk_pkg::REG_GRID_WIDE) ||
                                   (reg_idx == gpk_pkg::REG_GRID_HIGH));
        st.sweep_last = (sweep_idx_reg == CIDX_W'(CELLS - 1));
        st.op_clear   = (op_reg == gpk_pkg::OP_CLEAR);
        st.bad_req    = (wpx_reg == 16'd0) || (hpx_reg == 16'd0) ||
                        ({24'b0, id_reg} >= 32'(MAX_RECTS));
        st.div_last   = (div_cnt_reg == 4'd15);
        st.too_big    = (wb_reg > {10'b0, cols}) || (hb_reg > {10'b0, rows}) ||
                        ({18'b0, area} > 32'(free_reg));
        st.cell_hit   = cell_ok_reg && cell_q_reg[8];
        st.bnd_err    = (hit.l > cols) || (hit.r > cols) || (hit.t > rows) || (hit.b > rows);
        st.x_ge_r     = x_reg >= {1'b0, hit.r};
        st.i_last     = i_last;
        st.hb_one     = hb_one;
        st.skip_more  = x_reg < dest_reg;
        st.x_lt_xmax  = x_reg < xmax_reg;
        st.y_ge_ymax  = y_reg >= ymax_reg;
        st.mark_done  = ((phase_reg == gpk_pkg::PH_TOP) && i_last && hb_one) ||
                        ((phase_reg == gpk_pkg::PH_LEFT) && i_last);
        st.out_busy   = m_tvalid_reg && !m_tready;
        st.phase      = phase_reg;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg  <= gpk_pkg::GRID_RESET;
            gh_reg  <= gpk_pkg::GRID_RESET;
            bpw_reg <= gpk_pkg::BPIX_RESET;
            bph_reg <= gpk_pkg::BPIX_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                gpk_pkg::REG_GRID_WIDE:  gw_reg  <= pwdata[6:0];
                gpk_pkg::REG_GRID_HIGH:  gh_reg  <= pwdata[6:0];
                gpk_pkg::REG_BLOCK_PX_W: bpw_reg <= pwdata[12:0];
                gpk_pkg::REG_BLOCK_PX_H: bph_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            gpk_pkg::REG_GRID_WIDE:  prdata = {25'b0, gw_reg};
            gpk_pkg::REG_GRID_HIGH:  prdata = {25'b0, gh_reg};
            gpk_pkg::REG_BLOCK_PX_W: prdata = {19'b0, bpw_reg};
            gpk_pkg::REG_BLOCK_PX_H: prdata = {19'b0, bph_reg};
            default:                 prdata = '0;
        endcase
    end

    // cell owner store: sweep clears, mark writes, one read a cycle
    always_ff @(posedge aclk) begin
        if (cmd == gpk_pkg::CMD_SWEEP) begin
            cell_mem[sweep_idx_reg] <= 9'd0;
        end else if ((cmd == gpk_pkg::CMD_MARK) && addr_ok) begin
            cell_mem[cidx] <= {1'b1, id_reg};
        end
        if (cmd == gpk_pkg::CMD_READ) begin
            cell_q_reg  <= cell_mem[cidx];
            cell_ok_reg <= addr_ok;
        end
    end

    // rectangle bounds store
    always_ff @(posedge aclk) begin
        if (cmd == gpk_pkg::CMD_PLACE) begin
            bnd_mem[RIDX_W'(id_reg)] <= '{l: x7, t: y_reg[6:0], r: x7 + wb7,
                                          b: y_reg[6:0] + hb7};
        end
        if (cmd == gpk_pkg::CMD_CELL) begin
            bnd_q_reg  <= bnd_mem[RIDX_W'(cell_q_reg[7:0])];
            bnd_ok_reg <= {24'b0, cell_q_reg[7:0]} < 32'(MAX_RECTS);
        end
    end

    // search datapath
    always_ff @(posedge aclk) begin
        case (cmd)
            gpk_pkg::CMD_LOAD: begin
                op_reg  <= s_tuser;
                id_reg  <= s_tdata[7:0];
                wpx_reg <= s_tdata[23:8];
                hpx_reg <= s_tdata[39:24];
            end
            gpk_pkg::CMD_SWEEP_INIT: begin
                sweep_idx_reg <= '0;
                free_reg      <= FREE_W'({7'b0, cols} * {7'b0, rows});
            end
            gpk_pkg::CMD_SWEEP: begin
                sweep_idx_reg <= sweep_idx_reg + CIDX_W'(1);
            end
            gpk_pkg::CMD_DIVW_INIT: begin
                div_q_reg   <= wpx_reg - 16'd1;
                div_r_reg   <= '0;
                div_cnt_reg <= '0;
                div_sel_reg <= 1'b0;
            end
            gpk_pkg::CMD_DIV_STEP: begin
                // one quotient bit a cycle
                if (div_t >= {1'b0, dvs}) begin
                    div_r_reg <= 13'(div_t - {1'b0, dvs});
                    div_q_reg <= {div_q_reg[14:0], 1'b1};
                end else begin
                    div_r_reg <= div_t[12:0];
                    div_q_reg <= {div_q_reg[14:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            gpk_pkg::CMD_DIVW_SAVE: begin
                wb_reg      <= {1'b0, div_q_reg} + 17'd1;
                div_q_reg   <= hpx_reg - 16'd1;
                div_r_reg   <= '0;
                div_cnt_reg <= '0;
                div_sel_reg <= 1'b1;
            end
            gpk_pkg::CMD_DIVH_SAVE: begin
                hb_reg <= {1'b0, div_q_reg} + 17'd1;
            end
            gpk_pkg::CMD_SETUP: begin
                xmax_reg      <= {1'b0, cols - wb7} + 8'd1;
                ymax_reg      <= {1'b0, rows - hb7} + 8'd1;
                x_reg         <= '0;
                y_reg         <= '0;
                low_valid_reg <= 1'b0;
                phase_reg     <= gpk_pkg::PH_TOP;
                i_reg         <= '0;
            end
            gpk_pkg::CMD_ADV, gpk_pkg::CMD_MARK: begin
                // empty cell (or marked cell): step along the walk
                case (phase_reg)
                    gpk_pkg::PH_TOP: begin
                        if (!i_last) begin
                            i_reg <= i_reg + 7'd1;
                        end else if (!hb_one) begin
                            phase_reg <= gpk_pkg::PH_LEFT;
                            i_reg     <= 7'd1;
                        end
                    end
                    gpk_pkg::PH_LEFT: begin
                        if (!i_last) begin
                            i_reg <= i_reg + 7'd1;
                        end else begin
                            phase_reg <= gpk_pkg::PH_RIGHT;
                            i_reg     <= 7'd1;
                        end
                    end
                    gpk_pkg::PH_RIGHT: begin
                        i_reg <= i_reg + 7'd1;
                    end
                    default: begin
                        x_reg <= x_reg + 8'd1;
                    end
                endcase
            end
            gpk_pkg::CMD_HIT: begin
                // occupied cell met
                case (phase_reg)
                    gpk_pkg::PH_LEFT: begin
                        dest_reg  <= ({1'b0, hit.r} > xmax_reg) ? xmax_reg : {1'b0, hit.r};
                        x_reg     <= x_reg + {1'b0, wb7};
                        phase_reg <= gpk_pkg::PH_SKIP;
                    end
                    gpk_pkg::PH_SKIP: begin
                        if (!low_valid_reg || (hit.b < low_reg)) begin
                            low_valid_reg <= 1'b1;
                            low_reg       <= hit.b;
                        end
                        x_reg <= ({1'b0, hit.r} > x_reg) ? {1'b0, hit.r} : x_reg + 8'd1;
                    end
                    default: begin
                        if (!low_valid_reg || (hit.b < low_reg)) begin
                            low_valid_reg <= 1'b1;
                            low_reg       <= hit.b;
                        end
                        x_reg <= {1'b0, hit.r};
                    end
                endcase
            end
            gpk_pkg::CMD_PROBE: begin
                phase_reg <= gpk_pkg::PH_TOP;
                i_reg     <= '0;
            end
            gpk_pkg::CMD_ROW_END: begin
                // jump to the lowest bottom edge met, else next row
                if (low_valid_reg && ({1'b0, low_reg} > y_reg)) y_reg <= {1'b0, low_reg};
                else y_reg <= y_reg + 8'd1;
                x_reg         <= '0;
                low_valid_reg <= 1'b0;
                phase_reg     <= gpk_pkg::PH_TOP;
                i_reg         <= '0;
            end
            gpk_pkg::CMD_PLACE: begin
                free_reg  <= free_reg - FREE_W'(area);
                pl_reg    <= {13'b0, x7} * {7'b0, bw_eff};
                pt_reg    <= {13'b0, y_reg[6:0]} * {7'b0, bh_eff};
                phase_reg <= gpk_pkg::PH_TOP;
                i_reg     <= '0;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((cmd == gpk_pkg::CMD_RESULT) || (cmd == gpk_pkg::CMD_FAIL) ||
                     (cmd == gpk_pkg::CMD_CLR_DONE)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            gpk_pkg::CMD_RESULT: begin
                m_tuser_reg <= 1'b1;
                m_tdata_reg <= {4'b0, bpx, rpx, pt_reg, pl_reg, y_reg[6:0] + hb7,
                                x7 + wb7, y_reg[6:0], x7};
            end
            gpk_pkg::CMD_FAIL: begin
                m_tuser_reg <= 1'b0;
                m_tdata_reg <= '0;
            end
            gpk_pkg::CMD_CLR_DONE: begin
                m_tuser_reg <= 1'b1;
                m_tdata_reg <= '0;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/core/grid_rect_packer_top.sv]
`timescale 1ns / 1ps
// rectangle packer over a block grid
// input stream: one transaction per request; s_tuser is the opcode (add or clear),
// s_tdata carries rect_id, width_px and height_px. output stream: one transaction
// per request; m_tuser is placed_ok, m_tdata carries block and pixel bounds.
// configuration through the APB port: grid columns and rows in use and the block
// size in pixels; writing a grid dimension while idle also empties the grid.
// one request at a time. an add first runs two divisions that round the size up
// to blocks, then searches, reading cells from the cell store (one read port,
// registered), then marks the top row and left column of the placed rectangle.
// a clear sweeps the whole store: all MAX_BLOCKS_WIDE*MAX_BLOCKS_HIGH cells.
// after reset and after a grid dimension write while idle the block sweeps the
// whole store with s_tready low.
// a finished result waits in the output register; the next request is accepted
// meanwhile and only stalls at its own result while m_tready stays low.
module grid_rect_packer_top #(
    parameter int MAX_BLOCKS_WIDE = 64,
    parameter int MAX_BLOCKS_HIGH = 64,
    parameter int MAX_RECTS       = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rect_id [7:0], width_px [23:8], height_px [39:24]
    input  logic [gpk_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // left_block [6:0], top_block [13:7], right_block [20:14], bottom_block [27:21],
    // left_pixel [47:28], top_pixel [67:48], right_pixel [87:68],
    // bottom_pixel [107:88], zero [111:108]
    output logic [gpk_pkg::M_TDATA_W-1:0] m_tdata,
    // placed_ok [0]
    output logic                          m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gpk_pkg::APB_AW-1:0]    paddr,
    input  logic [gpk_pkg::APB_DW-1:0]    pwdata,
    output logic [gpk_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    gpk_pkg::gpk_cmd_t    cmd;
    gpk_pkg::gpk_status_t st;

    assign pready = 1'b1;

    // sequencer
    gpk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // stores, search registers and output register
    gpk_datapath #(
        .MAX_BLOCKS_WIDE (MAX_BLOCKS_WIDE),
        .MAX_BLOCKS_HIGH (MAX_BLOCKS_HIGH),
        .MAX_RECTS       (MAX_RECTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

endmodule

[rtl/core/gpk_checker.sv]
`timescale 1ns / 1ps
module gpk_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gpk_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // store sweep follows reset
    a_reset_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("request taken during reset sweep");

    // one request in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken back to back");

    // no new result in the cycle after a request is taken while no result waits
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

    // a failed add carries no bounds
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failed add with non-zero bounds");

endmodule

bind grid_rect_packer_top gpk_checker u_gpk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/grid_rect_packer_top_tb.sv]
`timescale 1ns / 1ps
module grid_rect_packer_top_tb;

    // mirror of the packer: grid cells, stored bounds, free count, registers
    class packer_scoreboard;
        typedef struct {
            int unsigned l, t, r, b;
        } box_t;
        typedef enum {HIT_NONE, HIT_ON_X, HIT_ON_Y, HIT_BAD} hit_kind_t;
        typedef struct {
            int unsigned f[9];
        } placement_t;

        bit [8:0]    owner [4096];
        box_t        bounds [256];
        int unsigned free_cnt;
        int unsigned grid_w, grid_h, px_w, px_h;
        bit          low_seen;
        int unsigned low_b;
        box_t        hit;
        placement_t  pending [$];
        int unsigned errors;

        function new();
            grid_w = gpk_pkg::GRID_RESET;
            grid_h = gpk_pkg::GRID_RESET;
            px_w   = gpk_pkg::BPIX_RESET;
            px_h   = gpk_pkg::BPIX_RESET;
            foreach (bounds[i]) bounds[i] = '{0, 0, 0, 0};
            errors = 0;
            wipe();
        endfunction

        function int unsigned cols();
            return (grid_w < 1) ? 1 : (grid_w > 64) ? 64 : grid_w;
        endfunction

        function int unsigned rows();
            return (grid_h < 1) ? 1 : (grid_h > 64) ? 64 : grid_h;
        endfunction

        function void wipe();
            foreach (owner[i]) owner[i] = '0;
            free_cnt = cols() * rows();
        endfunction

        function void write_reg(logic [1:0] idx, int unsigned val);
            case (idx)
                gpk_pkg::REG_GRID_WIDE:  begin grid_w = val & 'h7f; wipe(); end
                gpk_pkg::REG_GRID_HIGH:  begin grid_h = val & 'h7f; wipe(); end
                gpk_pkg::REG_BLOCK_PX_W: px_w = val & 'h1fff;
                gpk_pkg::REG_BLOCK_PX_H: px_h = val & 'h1fff;
                default: ;
            endcase
        endfunction

        function bit [8:0] cell_at(int unsigned x, int unsigned y);
            int unsigned i;
            i = y * cols() + x;
            return (i < 4096) ? owner[i] : 9'd0;
        endfunction

        function void set_cell(int unsigned x, int unsigned y, int unsigned id);
            int unsigned i;
            i = y * cols() + x;
            if (i < 4096) owner[i] = {1'b1, id[7:0]};
        endfunction

        function void lowest(int unsigned b);
            if (!low_seen || b < low_b) begin
                low_seen = 1;
                low_b    = b;
            end
        endfunction

        // look at top row, then left and right columns of a candidate spot
        function hit_kind_t probe(int unsigned x, int unsigned y, int unsigned w,
                                  int unsigned h);
            bit [8:0] c;
            for (int unsigned i = 0; i < w; i++) begin
                c = cell_at(x + i, y);
                if (c != 0) begin
                    hit = bounds[c[7:0]];
                    if (hit.l > cols() || hit.r > cols() || hit.t > rows() || hit.b > rows())
                        return HIT_BAD;
                    lowest(hit.b);
                    return HIT_ON_X;
                end
            end
            for (int unsigned i = 1; i < h; i++) begin
                c = cell_at(x, y + i);
                if (c != 0) begin
                    hit = bounds[c[7:0]];
                    return HIT_ON_Y;
                end
            end
            for (int unsigned i = 1; i < h; i++) begin
                c = cell_at(x + w - 1, y + i);
                if (c != 0) begin
                    hit = bounds[c[7:0]];
                    lowest(hit.b);
                    return HIT_ON_X;
                end
            end
            return HIT_NONE;
        endfunction

        function int unsigned skip_along(int unsigned x, int unsigned y, int unsigned dest);
            bit [8:0] c;
            box_t     bx;
            while (x < dest) begin
                c = cell_at(x, y);
                if (c != 0) begin
                    bx = bounds[c[7:0]];
                    lowest(bx.b);
                    x = (bx.r > x) ? bx.r : x + 1;
                end else begin
                    x++;
                end
            end
            return x;
        endfunction

        function bit place(int unsigned id, int unsigned wpx, int unsigned hpx,
                           ref int unsigned pos[8]);
            int unsigned bw, bh, wb, hb, xmax, ymax, x, y, dest;
            longint unsigned area;
            hit_kind_t k;
            bw = (px_w != 0) ? px_w : 1;
            bh = (px_h != 0) ? px_h : 1;
            if (wpx == 0 || hpx == 0 || id >= 256) return 0;
            wb = (bw + wpx - 1) / bw;
            hb = (bh + hpx - 1) / bh;
            area = longint'(wb) * hb;
            if (area > free_cnt) return 0;
            if (wb > cols() || hb > rows()) return 0;
            xmax = cols() - wb + 1;
            ymax = rows() - hb + 1;
            y = 0;
            forever begin
                x = 0;
                low_seen = 0;
                do begin
                    k = probe(x, y, wb, hb);
                    case (k)
                        HIT_NONE: begin
                            bounds[id] = '{x, y, x + wb, y + hb};
                            for (int unsigned i = 0; i < wb; i++) set_cell(x + i, y, id);
                            for (int unsigned i = 1; i < hb; i++) set_cell(x, y + i, id);
                            free_cnt -= wb * hb;
                            pos = '{x, y, x + wb, y + hb, x * bw, y * bh,
                                    x * bw + wpx, y * bh + hpx};
                            return 1;
                        end
                        HIT_ON_X: begin
                            if (x >= hit.r) return 0;
                            x = hit.r;
                        end
                        HIT_ON_Y: begin
                            dest = (hit.r > xmax) ? xmax : hit.r;
                            x = skip_along(x + wb, y, dest);
                        end
                        default: return 0;
                    endcase
                end while (x < xmax);
                if (low_seen && y < low_b) y = low_b;
                else y++;
                if (y >= ymax) return 0;
            end
        endfunction

        // an accepted request produces exactly one expected placement
        function void note_request(bit op, int unsigned id, int unsigned wpx,
                                   int unsigned hpx);
            int unsigned pos[8];
            placement_t  e;
            bit          ok;
            pos = '{0, 0, 0, 0, 0, 0, 0, 0};
            if (op == gpk_pkg::OP_CLEAR) begin
                wipe();
                ok = 1;
            end else begin
                ok = place(id, wpx, hpx, pos);
                if (!ok) pos = '{0, 0, 0, 0, 0, 0, 0, 0};
            end
            e.f[0] = ok;
            for (int i = 0; i < 4; i++) e.f[1 + i] = pos[i] & 'h7f;
            for (int i = 4; i < 8; i++) e.f[1 + i] = pos[i] & 'hfffff;
            pending.push_back(e);
        endfunction

        function void check_result(logic ok, logic [gpk_pkg::M_TDATA_W-1:0] d);
            placement_t e, a;
            string      names [9];
            names = '{"placed_ok", "left_block", "top_block", "right_block", "bottom_block",
                      "left_pixel", "top_pixel", "right_pixel", "bottom_pixel"};
            if (pending.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            a.f = '{ok, d[6:0], d[13:7], d[20:14], d[27:21],
                     d[47:28], d[67:48], d[87:68], d[107:88]};
            for (int i = 0; i < 9; i++)
                if (a.f[i] !== e.f[i]) begin
                    $error("%s: expected %0d, got %0d", names[i], e.f[i], a.f[i]);
                    errors++;
                end
        endfunction
    endclass

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gpk_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gpk_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [gpk_pkg::APB_AW-1:0]     paddr    = '0;
    logic [gpk_pkg::APB_DW-1:0]     pwdata   = '0;
    logic [gpk_pkg::APB_DW-1:0]     prdata;
    logic                           pready;

    packer_scoreboard sb = new();
    bit               rx_steady = 0;
    int unsigned      rx_hold = 0;

    grid_rect_packer_top u_top (.*);

    always #5 aclk = ~aclk;

    // result side: check each transaction, stall at random unless rx_steady is set
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        if (rx_steady) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0:        begin rx_hold <= $urandom_range(20, 120); m_tready <= 1'b0; end
                1, 2, 3:  begin rx_hold <= $urandom_range(0, 3);    m_tready <= 1'b0; end
                default:  m_tready <= 1'b1;
            endcase
        end
    end

    // request side: optional gap, then hold the transaction until accepted
    task automatic send_request(bit op, int unsigned id, int unsigned wpx, int unsigned hpx);
        int unsigned gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {hpx[15:0], wpx[15:0], id[7:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, id, wpx, hpx);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [gpk_pkg::APB_DW-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // mostly sizes of a few blocks, sometimes any 16-bit value
    function automatic int unsigned pick_size(int unsigned blocks, int unsigned bpx);
        int unsigned nb, v;
        if (bpx == 0) bpx = 1;
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
        nb = $urandom_range(1, (blocks < 6) ? blocks : 6);
        v  = (nb - 1) * bpx + $urandom_range(1, bpx);
        return (v > 65535) ? 65535 : v;
    endfunction

    task automatic random_phase(int unsigned count);
        bit op;
        for (int unsigned n = 0; n < count; n++) begin
            op = ($urandom_range(0, 24) == 0) ? gpk_pkg::OP_CLEAR : ~gpk_pkg::OP_CLEAR;
            send_request(op, $urandom_range(0, 255), pick_size(sb.cols(), sb.px_w),
                         pick_size(sb.rows(), sb.px_h));
            if (n == count / 2 && $urandom_range(0, 1) == 0) drain();
        end
    endtask

    initial begin
        int unsigned cfg [5][4];
        cfg = '{'{64, 64, 4096, 4096}, '{1, 1, 1, 1}, '{127, 0, 8191, 0},
                '{16, 16, 16, 16}, '{0, 0, 0, 0}};
        cfg[4] = '{$urandom_range(2, 24), $urandom_range(2, 24),
                   $urandom_range(1, 64), $urandom_range(1, 64)};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed requests under the reset configuration
        send_request(~gpk_pkg::OP_CLEAR, 0, 1, 1);
        send_request(~gpk_pkg::OP_CLEAR, 255, 65535, 16);
        send_request(~gpk_pkg::OP_CLEAR, 1, 0, 16);
        send_request(~gpk_pkg::OP_CLEAR, 2, 16, 0);
        send_request(~gpk_pkg::OP_CLEAR, 3, 1024, 1024);
        send_request(gpk_pkg::OP_CLEAR, 0, 0, 0);
        send_request(~gpk_pkg::OP_CLEAR, 7, 1024, 1024);
        send_request(~gpk_pkg::OP_CLEAR, 8, 1, 1);
        send_request(gpk_pkg::OP_CLEAR, 255, 65535, 65535);
        send_request(~gpk_pkg::OP_CLEAR, 3, 17, 33);
        send_request(~gpk_pkg::OP_CLEAR, 3, 40, 16);
        send_request(~gpk_pkg::OP_CLEAR, 9, 16, 64);
        send_request(~gpk_pkg::OP_CLEAR, 10, 48, 16);
        send_request(~gpk_pkg::OP_CLEAR, 11, 1000, 48);
        send_request(~gpk_pkg::OP_CLEAR, 12, 32, 32);
        send_request(~gpk_pkg::OP_CLEAR, 170, 21845, 16);
        send_request(~gpk_pkg::OP_CLEAR, 85, 16, 43690);
        send_request(~gpk_pkg::OP_CLEAR, 13, 16, 16);
        drain();

        // random phases over several register settings
        random_phase(180);
        for (int p = 0; p < 5; p++) begin
            drain();
            apb_write(gpk_pkg::REG_GRID_WIDE, cfg[p][0]);
            apb_write(gpk_pkg::REG_GRID_HIGH, cfg[p][1]);
            apb_write(gpk_pkg::REG_BLOCK_PX_W, cfg[p][2]);
            apb_write(gpk_pkg::REG_BLOCK_PX_H, cfg[p][3]);
            rx_steady = (p == 3);
            random_phase(p == 1 ? 60 : 110);
        end
        rx_steady = 0;

        drain();
        repeat (100) @(posedge aclk);
        if (sb.errors == 0) $display("grid_rect_packer_top test passed");
        else $display("grid_rect_packer_top test failed");
        $finish;
    end

    // run limit
    initial begin
        #500ms;
        $display("grid_rect_packer_top test failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/gpk_pkg.sv
rtl/core/gpk_ctrl.sv
rtl/core/gpk_datapath.sv
rtl/core/grid_rect_packer_top.sv
rtl/core/gpk_checker.sv
tb/grid_rect_packer_top_tb.sv
